[hw/rtl/rqi_pkg.sv]
// ----------------------------------------------------------------------------
// rqi_pkg: shared types and constants for the ray/quad intersection pipeline
// Holds the packed beat formats, the register index codes and the fixed
// word widths used by the front end, the divider and the back end.
// ----------------------------------------------------------------------------
package rqi_pkg;

  // Width of one coordinate component (signed Q9.10).
  localparam int CW = 20;
  // Width of a distance value (signed Q21.10).
  localparam int TW = 32;
  // Dividend width of the distance division (|num| scaled by 2^10).
  localparam int NW = 54;
  // Divisor width (|n.dir|).
  localparam int DW = 41;
  // Width of a plane coordinate (unsigned Q1.16).
  localparam int AW = 17;

  // Upper bound of the interior test on alpha and beta (1.0 in Q.36).
  localparam logic signed [63:0] ONE_Q36 = 64'sd68719476736;

  // Register index codes of the configuration port.
  typedef enum logic [2:0] {
    REG_NORMAL = 3'd0,
    REG_OFFSET = 3'd1,
    REG_CORNER = 3'd2,
    REG_EDGE_U = 3'd3,
    REG_EDGE_V = 3'd4,
    REG_SCALED = 3'd5,
    REG_THRESH = 3'd6
  } cfg_idx_t;

  // Configured quad, three components packed x in element 0.
  typedef struct packed {
    logic [2:0][CW-1:0] n;
    logic [TW-1:0]      d;
    logic [2:0][CW-1:0] q;
    logic [2:0][CW-1:0] u;
    logic [2:0][CW-1:0] v;
    logic [2:0][CW-1:0] w;
    logic [CW-1:0]      thr;
  } quad_cfg_t;

  // One incoming ray.
  typedef struct packed {
    logic [2:0][CW-1:0] o;
    logic [2:0][CW-1:0] dir;
    logic [TW-1:0]      t_min;
    logic [TW-1:0]      t_max;
  } ray_t;

  // Side information that travels alongside the divider.
  typedef struct packed {
    ray_t ray;
    logic miss;
    logic front;
    logic neg;
  } div_side_t;

  // One result beat.
  typedef struct packed {
    logic               hit;
    logic [TW-1:0]      t;
    logic [2:0][CW-1:0] pt;
    logic [2:0][CW-1:0] fn;
    logic               front;
    logic [AW-1:0]      ca;
    logic [AW-1:0]      cb;
  } res_t;

endpackage

[hw/rtl/rqi_front.sv]
// ----------------------------------------------------------------------------
// rqi_front: plane dot products and divider operand preparation
// Three register stages: per-axis products, the denominator and numerator
// sums, then the parallel test and the unsigned operands of the division.
// ----------------------------------------------------------------------------
module rqi_front import rqi_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_vld,
  input  ray_t            ray,
  input  quad_cfg_t       cfg,
  output logic            out_vld,
  output div_side_t       side,
  output logic [NW-1:0]   dvd,
  output logic [DW-1:0]   dsr
);

  logic                s1_vld;
  ray_t                s1_ray;
  logic signed [39:0]  s1_pd [3];
  logic signed [39:0]  s1_po [3];

  logic                s2_vld;
  ray_t                s2_ray;
  logic signed [41:0]  s2_den;
  logic signed [43:0]  s2_num;

  logic signed [41:0]  den_next;
  logic signed [41:0]  dot_o;
  logic signed [43:0]  num_next;
  logic [41:0]         den_abs;
  logic [43:0]         num_abs;
  logic                par;

  // Valid bits of the three stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld  <= 1'b0;
      s2_vld  <= 1'b0;
      out_vld <= 1'b0;
    end else if (en) begin
      s1_vld  <= in_vld;
      s2_vld  <= s1_vld;
      out_vld <= s2_vld;
    end
  end

  // Stage one: products of the normal with direction and origin.
  always_ff @(posedge clk) begin
    if (en) begin
      s1_ray <= ray;
      for (int i = 0; i < 3; i++) begin
        s1_pd[i] <= $signed(cfg.n[i]) * $signed(ray.dir[i]);
        s1_po[i] <= $signed(cfg.n[i]) * $signed(ray.o[i]);
      end
    end
  end

  // Stage two: denominator n.dir and numerator d - n.origin, both in Q.20.
  always_comb begin
    den_next = 42'(s1_pd[0]) + 42'(s1_pd[1]) + 42'(s1_pd[2]);
    dot_o    = 42'(s1_po[0]) + 42'(s1_po[1]) + 42'(s1_po[2]);
    num_next = 44'($signed({cfg.d, 10'b0})) - 44'(dot_o);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_ray <= s1_ray;
      s2_den <= den_next;
      s2_num <= num_next;
    end
  end

  // Stage three: magnitudes for the divider and the parallel test.
  always_comb begin
    den_abs = s2_den[41] ? 42'(-s2_den) : 42'(s2_den);
    num_abs = s2_num[43] ? 44'(-s2_num) : 44'(s2_num);
    par     = (s2_den == '0) || (den_abs < {12'b0, cfg.thr, 10'b0});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side.ray   <= s2_ray;
      side.miss  <= par;
      side.front <= s2_den[41];
      side.neg   <= s2_num[43] ^ s2_den[41];
      dvd        <= {num_abs, 10'b0};
      dsr        <= den_abs[DW-1:0];
    end
  end

endmodule

[hw/rtl/rqi_div.sv]
// ----------------------------------------------------------------------------
// rqi_div: pipelined restoring divider
// One quotient bit per register stage, most significant bit first. The
// remainder, the shifting dividend and the divisor travel with each beat.
// ----------------------------------------------------------------------------
module rqi_div import rqi_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_vld,
  input  div_side_t       in_side,
  input  logic [NW-1:0]   in_dvd,
  input  logic [DW-1:0]   in_dsr,
  output logic            out_vld,
  output div_side_t       out_side,
  output logic [NW-1:0]   quo
);

  logic            vld  [1:NW];
  logic [DW-1:0]   rem  [1:NW];
  logic [NW-1:0]   dvd  [1:NW];
  logic [DW-1:0]   dsr  [1:NW];
  div_side_t       side [1:NW];

  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic            src_vld;
    logic [DW-1:0]   src_rem;
    logic [NW-1:0]   src_dvd;
    logic [DW-1:0]   src_dsr;
    div_side_t       src_side;
    logic [DW:0]     trial;
    logic            ge;

    if (k == 0) begin : g_first
      assign src_vld  = in_vld;
      assign src_rem  = '0;
      assign src_dvd  = in_dvd;
      assign src_dsr  = in_dsr;
      assign src_side = in_side;
    end else begin : g_rest
      assign src_vld  = vld[k];
      assign src_rem  = rem[k];
      assign src_dvd  = dvd[k];
      assign src_dsr  = dsr[k];
      assign src_side = side[k];
    end

    // Bring down the next dividend bit and try the subtraction.
    assign trial = {src_rem, src_dvd[NW-1]};
    assign ge    = trial >= {1'b0, src_dsr};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= src_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1]  <= ge ? DW'(trial - {1'b0, src_dsr}) : trial[DW-1:0];
        dvd[k+1]  <= {src_dvd[NW-2:0], ge};
        dsr[k+1]  <= src_dsr;
        side[k+1] <= src_side;
      end
    end
  end

  assign out_vld  = vld[NW];
  assign out_side = side[NW];
  assign quo      = dvd[NW];

endmodule

[hw/rtl/rqi_back.sv]
// ----------------------------------------------------------------------------
// rqi_back: interval test, hit point and plane coordinates
// Seven register stages: signed distance and interval check, t*dir, the
// saturated hit point, cross-product terms, their differences, split
// products with the scaled normal and the alpha/beta sums.
// ----------------------------------------------------------------------------
module rqi_back import rqi_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_vld,
  input  div_side_t       side,
  input  logic [NW-1:0]   quo,
  input  quad_cfg_t       cfg,
  output logic            out_vld,
  output res_t            res
);

  localparam int TFW = NW + 1;

  logic [6:0] vld;

  // Stage one registers.
  logic signed [TFW-1:0] t_full;
  logic                  in_rng;
  logic signed [TW-1:0]  b1_t;
  logic                  b1_miss;
  logic                  b1_front;
  ray_t                  b1_ray;

  // Stage two registers.
  logic signed [51:0]    b2_prod [3];
  logic [2:0][CW-1:0]    b2_o;
  logic [TW-1:0]         b2_t;
  logic                  b2_miss;
  logic                  b2_front;

  // Stage three registers.
  logic signed [52:0]    hp_sum [3];
  logic [2:0][CW-1:0]    pt_next;
  logic [2:0][CW-1:0]    b3_pt;
  logic [TW-1:0]         b3_t;
  logic                  b3_miss;
  logic                  b3_front;

  // Stage four registers.
  logic signed [CW:0]    p [3];
  logic signed [40:0]    b4_pa [6];
  logic signed [40:0]    b4_pb [6];
  logic [2:0][CW-1:0]    b4_pt;
  logic [TW-1:0]         b4_t;
  logic                  b4_miss;
  logic                  b4_front;

  // Stage five registers.
  logic signed [41:0]    b5_ca [3];
  logic signed [41:0]    b5_cb [3];
  logic [2:0][CW-1:0]    b5_pt;
  logic [TW-1:0]         b5_t;
  logic                  b5_miss;
  logic                  b5_front;

  // Stage six registers.
  logic signed [40:0]    b6_ah [3];
  logic signed [41:0]    b6_al [3];
  logic signed [40:0]    b6_bh [3];
  logic signed [41:0]    b6_bl [3];
  logic [2:0][CW-1:0]    b6_pt;
  logic [TW-1:0]         b6_t;
  logic                  b6_miss;
  logic                  b6_front;

  // Stage seven registers.
  logic signed [63:0]    alpha_next;
  logic signed [63:0]    beta_next;
  logic signed [63:0]    b7_alpha;
  logic signed [63:0]    b7_beta;
  logic [2:0][CW-1:0]    b7_pt;
  logic [TW-1:0]         b7_t;
  logic                  b7_miss;
  logic                  b7_front;

  logic                  in_quad;

  // Valid bits travel with the beats.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[5:0], in_vld};
    end
  end

  // Stage one: apply the sign and check the inclusive interval.
  always_comb begin
    t_full = side.neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
    in_rng = (t_full >= TFW'($signed(side.ray.t_min))) &&
             (t_full <= TFW'($signed(side.ray.t_max)));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b1_t     <= t_full[TW-1:0];
      b1_miss  <= side.miss | ~in_rng;
      b1_front <= side.front;
      b1_ray   <= side.ray;
    end
  end

  // Stage two: distance times direction.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        b2_prod[i] <= b1_t * $signed(b1_ray.dir[i]);
      end
      b2_o     <= b1_ray.o;
      b2_t     <= b1_t;
      b2_miss  <= b1_miss;
      b2_front <= b1_front;
    end
  end

  // Stage three: hit point, floored to Q.10 and saturated.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      hp_sum[i] = 53'($signed({b2_o[i], 10'b0})) + 53'(b2_prod[i]);
      if ((hp_sum[i][52:29] == '0) || (hp_sum[i][52:29] == '1)) begin
        pt_next[i] = hp_sum[i][29:10];
      end else if (hp_sum[i][52]) begin
        pt_next[i] = {1'b1, {(CW-1){1'b0}}};
      end else begin
        pt_next[i] = {1'b0, {(CW-1){1'b1}}};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b3_pt    <= pt_next;
      b3_t     <= b2_t;
      b3_miss  <= b2_miss;
      b3_front <= b2_front;
    end
  end

  // Stage four: offset from the corner and the cross-product terms.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      p[i] = $signed({b3_pt[i][CW-1], b3_pt[i]}) - $signed({cfg.q[i][CW-1], cfg.q[i]});
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // Terms of cross(p, v).
      b4_pa[0] <= p[1] * $signed(cfg.v[2]);
      b4_pa[1] <= p[2] * $signed(cfg.v[1]);
      b4_pa[2] <= p[2] * $signed(cfg.v[0]);
      b4_pa[3] <= p[0] * $signed(cfg.v[2]);
      b4_pa[4] <= p[0] * $signed(cfg.v[1]);
      b4_pa[5] <= p[1] * $signed(cfg.v[0]);
      // Terms of cross(u, p).
      b4_pb[0] <= $signed(cfg.u[1]) * p[2];
      b4_pb[1] <= $signed(cfg.u[2]) * p[1];
      b4_pb[2] <= $signed(cfg.u[2]) * p[0];
      b4_pb[3] <= $signed(cfg.u[0]) * p[2];
      b4_pb[4] <= $signed(cfg.u[0]) * p[1];
      b4_pb[5] <= $signed(cfg.u[1]) * p[0];
      b4_pt    <= b3_pt;
      b4_t     <= b3_t;
      b4_miss  <= b3_miss;
      b4_front <= b3_front;
    end
  end

  // Stage five: cross-product components.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        b5_ca[i] <= 42'(b4_pa[2*i]) - 42'(b4_pa[2*i+1]);
        b5_cb[i] <= 42'(b4_pb[2*i]) - 42'(b4_pb[2*i+1]);
      end
      b5_pt    <= b4_pt;
      b5_t     <= b4_t;
      b5_miss  <= b4_miss;
      b5_front <= b4_front;
    end
  end

  // Stage six: scaled normal times the high and low halves of each component.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        b6_ah[i] <= $signed(cfg.w[i]) * $signed(b5_ca[i][41:21]);
        b6_al[i] <= $signed(cfg.w[i]) * $signed({1'b0, b5_ca[i][20:0]});
        b6_bh[i] <= $signed(cfg.w[i]) * $signed(b5_cb[i][41:21]);
        b6_bl[i] <= $signed(cfg.w[i]) * $signed({1'b0, b5_cb[i][20:0]});
      end
      b6_pt    <= b5_pt;
      b6_t     <= b5_t;
      b6_miss  <= b5_miss;
      b6_front <= b5_front;
    end
  end

  // Stage seven: recombine the halves into alpha and beta (Q.36).
  always_comb begin
    alpha_next = '0;
    beta_next  = '0;
    for (int i = 0; i < 3; i++) begin
      alpha_next = alpha_next + (64'(b6_ah[i]) <<< 21) + 64'(b6_al[i]);
      beta_next  = beta_next + (64'(b6_bh[i]) <<< 21) + 64'(b6_bl[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b7_alpha <= alpha_next;
      b7_beta  <= beta_next;
      b7_pt    <= b6_pt;
      b7_t     <= b6_t;
      b7_miss  <= b6_miss;
      b7_front <= b6_front;
    end
  end

  // Interior test and result assembly; a miss leaves every field at zero.
  always_comb begin
    in_quad = !b7_miss && !b7_alpha[63] && !b7_beta[63] &&
              (b7_alpha <= ONE_Q36) && (b7_beta <= ONE_Q36);
    res = '0;
    if (in_quad) begin
      res.hit   = 1'b1;
      res.t     = b7_t;
      res.pt    = b7_pt;
      res.front = b7_front;
      res.ca    = b7_alpha[36:20];
      res.cb    = b7_beta[36:20];
      for (int i = 0; i < 3; i++) begin
        if (b7_front) begin
          res.fn[i] = cfg.n[i];
        end else if (cfg.n[i] == {1'b1, {(CW-1){1'b0}}}) begin
          res.fn[i] = {1'b0, {(CW-1){1'b1}}};
        end else begin
          res.fn[i] = CW'(-$signed(cfg.n[i]));
        end
      end
    end
  end

  assign out_vld = vld[6];

endmodule

[hw/rtl/ray_quad_intersect_top.sv]
// ----------------------------------------------------------------------------
// ray_quad_intersect_top: ray against parallelogram intersection pipeline
// Tests each incoming ray against the configured quad and returns one result
// beat per ray with hit flag, distance, hit point, facing normal and plane
// coordinates.
// ----------------------------------------------------------------------------
// Usage:
// The quad is set through the cfg channel (index 0..6, always ready); write
// it only while no ray is in flight. Rays enter on the ray channel and one
// result beat per ray leaves on the res channel, in order.
// A ray may be accepted in every cycle while the output queue is not full.
// On its way to res_valid each beat passes 3 front stages (plane dot
// products), 54 divider stages that form t (one quotient bit per stage),
// 7 back stages (interval test, hit point and plane coordinates) and the
// output queue, the first front stage being loaded at the accepting edge.
// Results land in a two-beat output queue. While that queue is full the
// whole pipeline holds and ray_ready is low; with one result waiting, new
// rays are still taken. A stalled receiver loses and repeats nothing.
// Reset clears all valid bits and the queue, loads the quad registers with
// zero and the parallel threshold with a raw value of 1 (one LSB).
// ----------------------------------------------------------------------------
module ray_quad_intersect_top import rqi_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  // Configuration channel.
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [2:0]           cfg_index,
  input  logic [59:0]          cfg_data,
  // Ray channel.
  input  logic                 ray_valid,
  output logic                 ray_ready,
  input  logic signed [19:0]   origin_x,
  input  logic signed [19:0]   origin_y,
  input  logic signed [19:0]   origin_z,
  input  logic signed [19:0]   dir_x,
  input  logic signed [19:0]   dir_y,
  input  logic signed [19:0]   dir_z,
  input  logic signed [31:0]   t_min,
  input  logic signed [31:0]   t_max,
  // Result channel.
  output logic                 res_valid,
  input  logic                 res_ready,
  output logic                 hit,
  output logic signed [31:0]   hit_t,
  output logic signed [19:0]   point_x,
  output logic signed [19:0]   point_y,
  output logic signed [19:0]   point_z,
  output logic signed [19:0]   facing_normal_x,
  output logic signed [19:0]   facing_normal_y,
  output logic signed [19:0]   facing_normal_z,
  output logic                 front_face,
  output logic [16:0]          coord_a,
  output logic [16:0]          coord_b
);

  quad_cfg_t   cfg;
  ray_t        ray;
  logic        en;

  logic        f_vld;
  div_side_t   f_side;
  logic [NW-1:0] f_dvd;
  logic [DW-1:0] f_dsr;

  logic        d_vld;
  div_side_t   d_side;
  logic [NW-1:0] d_quo;

  logic        b_vld;
  res_t        b_res;

  res_t        qmem [2];
  logic [1:0]  cnt;
  logic        wr_ptr;
  logic        rd_ptr;
  logic        push;
  logic        pop;
  res_t        head;

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.n   <= '0;
      cfg.d   <= '0;
      cfg.q   <= '0;
      cfg.u   <= '0;
      cfg.v   <= '0;
      cfg.w   <= '0;
      cfg.thr <= CW'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        REG_NORMAL: cfg.n   <= cfg_data;
        REG_OFFSET: cfg.d   <= cfg_data[TW-1:0];
        REG_CORNER: cfg.q   <= cfg_data;
        REG_EDGE_U: cfg.u   <= cfg_data;
        REG_EDGE_V: cfg.v   <= cfg_data;
        REG_SCALED: cfg.w   <= cfg_data;
        REG_THRESH: cfg.thr <= cfg_data[CW-1:0];
        default: begin
        end
      endcase
    end
  end

  // Pack the incoming beat.
  always_comb begin
    ray.o     = {origin_z, origin_y, origin_x};
    ray.dir   = {dir_z, dir_y, dir_x};
    ray.t_min = t_min;
    ray.t_max = t_max;
  end

  // The pipeline advances whenever the output queue has a free slot.
  assign en        = (cnt != 2'd2);
  assign ray_ready = en;

  rqi_front u_front (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (ray_valid),
    .ray     (ray),
    .cfg     (cfg),
    .out_vld (f_vld),
    .side    (f_side),
    .dvd     (f_dvd),
    .dsr     (f_dsr)
  );

  rqi_div u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (f_vld),
    .in_side  (f_side),
    .in_dvd   (f_dvd),
    .in_dsr   (f_dsr),
    .out_vld  (d_vld),
    .out_side (d_side),
    .quo      (d_quo)
  );

  rqi_back u_back (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (d_vld),
    .side    (d_side),
    .quo     (d_quo),
    .cfg     (cfg),
    .out_vld (b_vld),
    .res     (b_res)
  );

  // Two-beat output queue.
  assign push = b_vld && en;
  assign pop  = res_valid && res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt    <= '0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        cnt <= cnt + 2'd1;
      end else if (pop && !push) begin
        cnt <= cnt - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      qmem[wr_ptr] <= b_res;
    end
  end

  // Drive the result ports from the queue head.
  assign head            = qmem[rd_ptr];
  assign res_valid       = (cnt != 2'd0);
  assign hit             = head.hit;
  assign hit_t           = head.t;
  assign point_x         = head.pt[0];
  assign point_y         = head.pt[1];
  assign point_z         = head.pt[2];
  assign facing_normal_x = head.fn[0];
  assign facing_normal_y = head.fn[1];
  assign facing_normal_z = head.fn[2];
  assign front_face      = head.front;
  assign coord_a         = head.ca;
  assign coord_b         = head.cb;

`ifndef SYNTHESIS
  // The queue never holds more than two beats.
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst) cnt <= 2'd2)
    else $error("output queue count out of range");

  // A full queue freezes the pipeline, so nothing is pushed into it.
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    (cnt == 2'd2) |-> !push)
    else $error("push into full output queue");

  // A miss beat carries zeros in every field.
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !hit) |-> (hit_t == '0 && point_x == '0 && point_y == '0 &&
      point_z == '0 && facing_normal_x == '0 && facing_normal_y == '0 &&
      facing_normal_z == '0 && !front_face && coord_a == '0 && coord_b == '0))
    else $error("miss beat with non-zero fields");

  // Plane coordinates of a hit never exceed one.
  a_coord_range: assert property (@(posedge clk) disable iff (rst)
    (res_valid && hit) |-> (coord_a <= 17'd65536 && coord_b <= 17'd65536))
    else $error("plane coordinate above one");

  // A beat waiting at the output with the receiver stalled stays put.
  a_head_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=> (res_valid && $stable(head)))
    else $error("stalled result beat changed");
`endif

endmodule
